/* hdl/indexed_palette_to_rgba_defines.svh */
// Assertion macros used by the palette expander checker.
// Included by file name; no other dependencies.
`ifndef INDEXED_PALETTE_TO_RGBA_DEFINES_SVH
`define INDEXED_PALETTE_TO_RGBA_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define IPAL_CHECK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Property checked on every clock edge, reset included.
`define IPAL_CHECK_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

/* hdl/ipal_pkg.sv */
// Shared types and constants of the indexed palette to RGBA expander.
// No dependencies.
`timescale 1ns / 1ps

package ipal_pkg;

	localparam int ENTRY_W     = 8;
	localparam int ROW_WIDTH_W = 13;
	localparam int TRANS_W     = 9;
	localparam int DEPTH_W     = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 13;
	localparam int RGBA_W      = 32;

	typedef enum logic [1:0] {
		OP_PIXEL     = 2'd0,
		OP_PAL_WRITE = 2'd1,
		OP_PAL_CLEAR = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PIXEL_DEPTH = 2'd0,
		REG_ROW_WIDTH   = 2'd1,
		REG_TRANS_COUNT = 2'd2
	} cfg_reg_t;

	typedef enum logic [DEPTH_W-1:0] {
		DEPTH_1BIT = 2'd0,
		DEPTH_2BIT = 2'd1,
		DEPTH_4BIT = 2'd2,
		DEPTH_8BIT = 2'd3
	} depth_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic [7:0]         packed_byte;
		logic [ENTRY_W-1:0] entry_index;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic [7:0]         trans_alpha;
	} ipal_in_t;

	typedef struct packed {
		logic [RGBA_W-1:0] rgba_pixel;
		logic              row_end;
		logic              last;
	} ipal_out_t;

endpackage

/* hdl/ipal_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ipal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* hdl/indexed_palette_to_rgba.sv */
// Indexed palette to RGBA expander: unpacks pixel bytes and looks each index up.
// Depends on ipal_pkg and ipal_ram.
`timescale 1ns / 1ps

//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------
//  src     | src_valid/src_stall| ipal_in_t  (pixel byte, palette op)
//  dst     | dst_valid/dst_stall| ipal_out_t (one RGBA word per pixel)
//  cfg     | cfg_wr_en          | cfg_index, cfg_data
//
// A pixel byte occupies the unpack stage until its pixels (1 to 8) are emitted,
// one per cycle unless the output stalls; the single palette read port sets this
// rate. Palette write and clear do not wait on the output.
// Reset clears the per-entry valid bits at once; no clearing pass is needed.
// A stalled output backs up through the read stage into the unpack stage.

module indexed_palette_to_rgba
	import ipal_pkg::*;
#(
	parameter int PALETTE_ENTRIES = 256,
	parameter int MAX_ROW_WIDTH   = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  src_valid,
	output logic                  src_stall,
	input  ipal_in_t              src_data,
	output logic                  dst_valid,
	input  logic                  dst_stall,
	output ipal_out_t             dst_data,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W = $clog2(PALETTE_ENTRIES);
	localparam int COL_W = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
	localparam int WID_W = $clog2(MAX_ROW_WIDTH + 1);
	localparam int EXT_W = (WID_W > ROW_WIDTH_W) ? WID_W : ROW_WIDTH_W;
	localparam int LIM_W = ENTRY_W + 1;
	localparam logic [LIM_W-1:0] ENTRY_LIMIT = LIM_W'(PALETTE_ENTRIES);
	localparam logic [EXT_W-1:0] WIDTH_LIMIT = EXT_W'(MAX_ROW_WIDTH);

	// configuration
	logic [DEPTH_W-1:0]     depth_q;
	logic [ROW_WIDTH_W-1:0] row_width_q;
	logic [TRANS_W-1:0]     trans_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q       <= DEPTH_8BIT;
			row_width_q   <= ROW_WIDTH_W'(1);
			trans_count_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_PIXEL_DEPTH: depth_q       <= cfg_data[DEPTH_W-1:0];
				REG_ROW_WIDTH:   row_width_q   <= cfg_data[ROW_WIDTH_W-1:0];
				REG_TRANS_COUNT: trans_count_q <= cfg_data[TRANS_W-1:0];
				default: ;
			endcase
		end
	end

	logic [EXT_W-1:0] row_ext;
	logic [EXT_W-1:0] width_eff;

	always_comb begin
		row_ext = EXT_W'(row_width_q);
		if (row_ext == '0) begin
			width_eff = EXT_W'(1);
		end else if (row_ext > WIDTH_LIMIT) begin
			width_eff = WIDTH_LIMIT;
		end else begin
			width_eff = row_ext;
		end
	end

	// unpack stage
	logic         vld_s1;
	ipal_in_t     item_s1;
	logic [7:0]   bits_s1;
	logic [2:0]   slot_s1;
	logic [COL_W-1:0] col_q;

	// read stage
	logic         vld_s2;
	logic         hit_s2;
	logic         row_end_s2;
	logic         last_s2;

	// output register
	logic         out_vld_q;
	ipal_out_t    out_q;

	logic         out_free;
	logic         issue_ok;
	logic         is_pixel;
	logic         step;
	logic         done_s1;
	logic         src_acc;
	logic         op_known;
	logic [2:0]   slot_max;
	logic         slot_last;
	logic         row_done;
	logic         pix_last;
	logic [7:0]   pix_idx;
	logic         pix_in_range;
	logic [IDX_W-1:0] rd_addr;
	logic         rd_hit;
	logic [RGBA_W-1:0] rd_data;
	logic         wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [RGBA_W-1:0] wr_data;
	logic [7:0]   wr_alpha;

	assign out_free = !out_vld_q || !dst_stall;
	assign issue_ok = !vld_s2 || out_free;
	assign is_pixel = (item_s1.operation == OP_PIXEL);
	assign step     = vld_s1 && is_pixel && issue_ok;

	assign slot_max  = 3'((4'd8 >> depth_q) - 4'd1);
	assign slot_last = (slot_s1 == slot_max);
	assign row_done  = (EXT_W'(col_q) + EXT_W'(1)) >= width_eff;
	assign pix_last  = row_done || slot_last;

	assign done_s1   = vld_s1 && (!is_pixel || (issue_ok && pix_last));
	assign src_stall = vld_s1 && !done_s1;
	assign src_acc   = src_valid && !src_stall;

	always_comb begin
		op_known = src_data.operation inside {OP_PIXEL, OP_PAL_WRITE, OP_PAL_CLEAR};
		case (depth_q)
			DEPTH_1BIT: pix_idx = {7'b0, bits_s1[7]};
			DEPTH_2BIT: pix_idx = {6'b0, bits_s1[7:6]};
			DEPTH_4BIT: pix_idx = {4'b0, bits_s1[7:4]};
			default:    pix_idx = bits_s1;
		endcase
	end

	assign pix_in_range = LIM_W'(pix_idx) < ENTRY_LIMIT;
	assign rd_addr      = pix_idx[IDX_W-1:0];

	// palette writes happen in order with the lookups of earlier bytes
	assign wr_alpha = (LIM_W'(item_s1.entry_index) < trans_count_q) ?
		item_s1.trans_alpha : 8'hff;
	assign wr_en    = vld_s1 && (item_s1.operation == OP_PAL_WRITE) &&
		(LIM_W'(item_s1.entry_index) < ENTRY_LIMIT);
	assign wr_addr  = item_s1.entry_index[IDX_W-1:0];
	assign wr_data  = {wr_alpha, item_s1.blue, item_s1.green, item_s1.red};

	// entry valid bits stand in for the zeroed palette
	logic [PALETTE_ENTRIES-1:0] pal_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_vld_q <= '0;
		end else if (vld_s1 && item_s1.operation == OP_PAL_CLEAR) begin
			pal_vld_q <= '0;
		end else if (wr_en) begin
			pal_vld_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_hit = pix_in_range && pal_vld_q[rd_addr];

	ipal_ram #(
		.WIDTH (RGBA_W),
		.DEPTH (PALETTE_ENTRIES)
	) u_palette (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (step),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// unpack stage control and payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			col_q  <= '0;
		end else begin
			if (!vld_s1 || done_s1) begin
				vld_s1 <= src_acc && op_known;
			end
			if (step) begin
				col_q <= row_done ? '0 : col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (src_acc) begin
			item_s1 <= src_data;
			bits_s1 <= src_data.packed_byte;
			slot_s1 <= '0;
		end else if (step) begin
			bits_s1 <= bits_s1 << (4'd1 << depth_q);
			slot_s1 <= slot_s1 + 3'd1;
		end
	end

	// read stage: hold while the output register is full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (issue_ok) begin
			vld_s2 <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			hit_s2     <= rd_hit;
			row_end_s2 <= row_done;
			last_s2    <= pix_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && vld_s2) begin
			out_q.rgba_pixel <= hit_s2 ? rd_data : '0;
			out_q.row_end    <= row_end_s2;
			out_q.last       <= last_s2;
		end
	end

	assign dst_valid = out_vld_q;
	assign dst_data  = out_q;

endmodule

/* hdl/ipal_checker.sv */
// Port-level checks for the palette expander, bound to the top level.
// Depends on ipal_pkg and indexed_palette_to_rgba_defines.svh.
`timescale 1ns / 1ps
`include "indexed_palette_to_rgba_defines.svh"

module ipal_checker
	import ipal_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  src_valid,
	input logic                  src_stall,
	input ipal_in_t              src_data,
	input logic                  dst_valid,
	input logic                  dst_stall,
	input ipal_out_t             dst_data,
	input logic                  cfg_wr_en,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	// a held result transaction keeps its payload
	`IPAL_CHECK(a_dst_hold, clk, arst_n, dst_valid && dst_stall |=> dst_valid && $stable(dst_data), "dst payload changed while stalled")

	// a row end always closes the results of its byte
	`IPAL_CHECK(a_row_end_last, clk, arst_n, dst_valid && dst_data.row_end |-> dst_data.last, "row end without last")

	// source stalls only while a byte accepted earlier is still being expanded
	`IPAL_CHECK(a_stall_cause, clk, arst_n, src_stall |-> $past(src_stall) || $past(src_valid && !src_stall), "src stalled with nothing in flight")

	// nothing leaves while reset is held
	`IPAL_CHECK_ALWAYS(a_reset_quiet, clk, !arst_n |-> !dst_valid, "dst valid during reset")

endmodule

bind indexed_palette_to_rgba ipal_checker u_ipal_checker (.*);
